/* rtl/lmwc_pkg.sv */
// Package for the letter multiset word checker.
// Commands, verdict codes, register indexes and fixed field widths.
// No dependencies.
`default_nettype none

package lmwc_pkg;

    localparam int LETTER_W  = 8;
    localparam int CMD_W     = 2;
    localparam int VERDICT_W = 2;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WORD  = 2'd2;

    localparam logic [VERDICT_W-1:0] VERDICT_MATCH   = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_LONG    = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_SHORT   = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_MISSING = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'd1;

    localparam logic [CFG_W-1:0] MIN_LEN_RST = 4'd2;
    localparam logic [CFG_W-1:0] MAX_LEN_RST = 4'd15;

endpackage

`default_nettype wire

/* rtl/lmwc_in_if.sv */
// Request channel into the checker: command, letter, last-letter flag.
// Depends on lmwc_pkg.
`default_nettype none

interface lmwc_in_if;
    logic                          valid;
    logic                          ready;
    logic [lmwc_pkg::CMD_W-1:0]    command;
    logic [lmwc_pkg::LETTER_W-1:0] letter;
    logic                          last_letter;

    modport source (output valid, command, letter, last_letter, input ready);
    modport sink   (input valid, command, letter, last_letter, output ready);
endinterface

`default_nettype wire

/* rtl/lmwc_out_if.sv */
// Result channel out of the checker: verdict, word length, pool size.
// Depends on lmwc_pkg.
`default_nettype none

interface lmwc_out_if #(
    parameter int LEN_W  = 5,
    parameter int POOL_W = 4
);
    logic                           valid;
    logic                           ready;
    logic [lmwc_pkg::VERDICT_W-1:0] verdict;
    logic [LEN_W-1:0]               word_length;
    logic [POOL_W-1:0]              pool_size;

    modport source (output valid, verdict, word_length, pool_size, input ready);
    modport sink   (input valid, verdict, word_length, pool_size, output ready);
endinterface

`default_nettype wire

/* rtl/lmwc_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on lmwc_pkg.
`default_nettype none

interface lmwc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lmwc_pkg::CFG_IDX_W-1:0] index;
    logic [lmwc_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/letter_multiset_word_checker_top.sv */
// Letter multiset word checker, top level.
// Depends on lmwc_pkg, lmwc_in_if, lmwc_out_if, lmwc_cfg_if, lmwc_cnt_mem.
//
// Usage:
//   i_in carries requests: CLEAR empties the letter pool, ADD puts one letter
//   into the pool (dropped when the pool is full or the code is outside the
//   alphabet), WORD streams one letter of a candidate word. The WORD request
//   flagged last_letter produces one result on o_out: verdict (match, too
//   long, too short, letters missing), word length (saturating at capacity
//   plus one) and the current pool size. Other requests produce nothing.
//   i_cfg writes the shortest matching length (index 0) and the longest
//   (index 1); it is always ready and should only be written while idle.
// Timing:
//   One request per cycle while no second result waits: each letter is one
//   read-modify-write of its counters, read at accept into the input stage
//   and resolved from there into the result register, which drives
//   o_out.valid. Back-to-back hits on one letter are forwarded.
// Reset and stall:
//   Reset empties the pool and the word at once (valid bits per letter)
//   and restores the length limits to 2 and 15. If o_out stalls, the result
//   is held; requests keep flowing until a second result is waiting.
`default_nettype none

module letter_multiset_word_checker_top #(
    parameter int MAX_LETTERS = 15,
    parameter int ALPHABET    = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lmwc_in_if.sink          i_in,
    lmwc_out_if.source       o_out,
    lmwc_cfg_if.sink         i_cfg
);

    localparam int AW     = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int POOL_W = $clog2(MAX_LETTERS + 1);
    localparam int LEN_W  = $clog2(MAX_LETTERS + 2);
    localparam int CMP_W  = (LEN_W > lmwc_pkg::CFG_W) ? LEN_W : lmwc_pkg::CFG_W;
    localparam int LW     = lmwc_pkg::LETTER_W;

    localparam logic [LW:0]       LTR_LIM  = (LW + 1)'(ALPHABET);
    localparam logic [POOL_W-1:0] POOL_MAX = POOL_W'(MAX_LETTERS);
    localparam logic [LEN_W-1:0]  LEN_SAT  = LEN_W'(MAX_LETTERS + 1);

    // configuration
    logic [lmwc_pkg::CFG_W-1:0] r_min_len;
    logic [lmwc_pkg::CFG_W-1:0] r_max_len;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= lmwc_pkg::MIN_LEN_RST;
            r_max_len <= lmwc_pkg::MAX_LEN_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lmwc_pkg::CFG_MIN_LEN: r_min_len <= i_cfg.data;
                lmwc_pkg::CFG_MAX_LEN: r_max_len <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // input stage
    logic                          r_s1_vld;
    logic [lmwc_pkg::CMD_W-1:0]    r_cmd;
    logic [LW-1:0]                 r_ch;
    logic                          r_last;
    logic                          r_out_vld;
    logic                          in_fire;
    logic                          s1_res;
    logic                          s1_go;

    assign s1_res      = r_s1_vld && (r_cmd == lmwc_pkg::CMD_WORD) && r_last;
    assign s1_go       = r_s1_vld && (!s1_res || !r_out_vld || o_out.ready);
    assign i_in.ready  = !r_s1_vld || s1_go;
    assign in_fire     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd  <= i_in.command;
            r_ch   <= i_in.letter;
            r_last <= i_in.last_letter;
        end
    end

    // per-letter counters: pool histogram and uses by the current word
    logic [POOL_W-1:0] pool_c;
    logic [POOL_W-1:0] used_c;
    logic              pool_wr;
    logic              used_wr;
    logic              pool_clr;
    logic              used_clr;

    lmwc_cnt_mem #(.DEPTH(ALPHABET), .DW(POOL_W)) u_pool (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (i_in.letter[AW-1:0]),
        .i_wr_en   (pool_wr),
        .i_wr_addr (r_ch[AW-1:0]),
        .i_wr_data (pool_c + POOL_W'(1)),
        .i_clr     (pool_clr),
        .o_rd_data (pool_c)
    );

    lmwc_cnt_mem #(.DEPTH(ALPHABET), .DW(POOL_W)) u_used (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (i_in.letter[AW-1:0]),
        .i_wr_en   (used_wr),
        .i_wr_addr (r_ch[AW-1:0]),
        .i_wr_data (used_c + POOL_W'(1)),
        .i_clr     (used_clr),
        .o_rd_data (used_c)
    );

    // word and pool totals
    logic [POOL_W-1:0]              r_pool_total;
    logic [POOL_W-1:0]              n_pool_total;
    logic [LEN_W-1:0]               r_word_len;
    logic [LEN_W-1:0]               n_word_len;
    logic                           r_short;
    logic                           n_short;
    logic                           in_range;
    logic                           can_use;
    logic                           short_now;
    logic [LEN_W-1:0]               len_inc;
    logic [lmwc_pkg::VERDICT_W-1:0] verdict;

    assign in_range  = {1'b0, r_ch} < LTR_LIM;
    assign can_use   = in_range && (used_c < pool_c);
    assign short_now = r_short || !can_use;
    assign len_inc   = (r_word_len < LEN_SAT) ? r_word_len + LEN_W'(1) : r_word_len;

    // verdict priority: too long, too short, missing letters
    always_comb begin
        if ((len_inc > LEN_W'(r_pool_total)) || (CMP_W'(len_inc) > CMP_W'(r_max_len))) begin
            verdict = lmwc_pkg::VERDICT_LONG;
        end else if (CMP_W'(len_inc) < CMP_W'(r_min_len)) begin
            verdict = lmwc_pkg::VERDICT_SHORT;
        end else if (short_now) begin
            verdict = lmwc_pkg::VERDICT_MISSING;
        end else begin
            verdict = lmwc_pkg::VERDICT_MATCH;
        end
    end

    always_comb begin
        n_pool_total = r_pool_total;
        n_word_len   = r_word_len;
        n_short      = r_short;
        pool_wr      = 1'b0;
        used_wr      = 1'b0;
        pool_clr     = 1'b0;
        used_clr     = 1'b0;
        if (s1_go) begin
            unique case (r_cmd)
                lmwc_pkg::CMD_CLEAR: begin
                    pool_clr     = 1'b1;
                    n_pool_total = '0;
                end
                lmwc_pkg::CMD_ADD: begin
                    if (in_range && (r_pool_total < POOL_MAX)) begin
                        pool_wr      = 1'b1;
                        n_pool_total = r_pool_total + POOL_W'(1);
                    end
                end
                lmwc_pkg::CMD_WORD: begin
                    used_wr = can_use;
                    if (r_last) begin
                        used_clr   = 1'b1;
                        n_word_len = '0;
                        n_short    = 1'b0;
                    end else begin
                        n_word_len = len_inc;
                        n_short    = short_now;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_total <= '0;
            r_word_len   <= '0;
            r_short      <= 1'b0;
        end else begin
            r_pool_total <= n_pool_total;
            r_word_len   <= n_word_len;
            r_short      <= n_short;
        end
    end

    // result register
    logic [lmwc_pkg::VERDICT_W-1:0] r_verdict;
    logic [LEN_W-1:0]               r_len;
    logic [POOL_W-1:0]              r_pool_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go && s1_res) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_res) begin
            r_verdict   <= verdict;
            r_len       <= len_inc;
            r_pool_size <= r_pool_total;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.verdict     = r_verdict;
    assign o_out.word_length = r_len;
    assign o_out.pool_size   = r_pool_size;

`ifndef SYNTHESIS
    a_res_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_res) |=> o_out.valid)
        else $error("resolved last letter did not load the result register");

    a_pool_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool_total <= POOL_MAX)
        else $error("pool total beyond capacity");

    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_len <= LEN_SAT)
        else $error("word length beyond saturation");

    a_word_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_res) |=> ((r_word_len == '0) && !r_short))
        else $error("word state not cleared after last letter");

    a_no_stall_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> r_out_vld)
        else $error("stalled result lost");
`endif

endmodule

`default_nettype wire

/* rtl/lmwc_cnt_mem.sv */
// Per-letter counter memory: one write port, one registered read port,
// valid bits with a clear of all entries at once, and write-to-read forwarding. No deps.
`default_nettype none

module lmwc_cnt_mem #(
    parameter int DEPTH = 256,
    parameter int DW    = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_clr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0]    r_rd_data;
    logic [AW-1:0]    r_rd_addr;
    logic             r_fwd_ok;
    logic [AW-1:0]    r_fwd_addr;
    logic [DW-1:0]    r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
        if (i_wr_en) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    // clear wins over a same-cycle write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_fwd_ok <= 1'b0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_wr_en) begin
                r_fwd_ok <= 1'b1;
            end
        end
    end

    // last write may have landed after the registered read sampled the array
    always_comb begin
        if (!r_vld[r_rd_addr]) begin
            o_rd_data = '0;
        end else if (r_fwd_ok && (r_fwd_addr == r_rd_addr)) begin
            o_rd_data = r_fwd_data;
        end else begin
            o_rd_data = r_rd_data;
        end
    end

endmodule

`default_nettype wire

/* tb/sv/lmwc_verdict_checker.sv */
`timescale 1ns / 1ps
// Verdict checker for the letter multiset word checker: watches the request,
// result and register channels, predicts each verdict and compares it.
// Depends on lmwc_pkg, lmwc_in_if, lmwc_out_if and lmwc_cfg_if.
module lmwc_verdict_checker #(
    parameter int MAX_LETTERS = 15,
    parameter int ALPHABET    = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lmwc_in_if        i_req,
    lmwc_out_if       i_res,
    lmwc_cfg_if       i_cfg,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [lmwc_pkg::VERDICT_W-1:0] verdict;
        logic [4:0]                     word_length;
        logic [3:0]                     pool_size;
    } t_verdict;

    t_verdict    verdicts_due[$];
    int unsigned pool_cnt[ALPHABET];
    int unsigned used_cnt[ALPHABET];
    int unsigned pool_total;
    int unsigned word_len;
    bit          short_flag;
    int unsigned min_len;
    int unsigned max_len;
    int          fails;

    task automatic forget_word();
        foreach (used_cnt[i]) used_cnt[i] = 0;
        word_len   = 0;
        short_flag = 1'b0;
    endtask

    task automatic empty_pool();
        foreach (pool_cnt[i]) pool_cnt[i] = 0;
        pool_total = 0;
    endtask

    // Applies one accepted request; a last word letter queues one verdict.
    task automatic spell(input logic [lmwc_pkg::CMD_W-1:0] cmd,
                         input logic [lmwc_pkg::LETTER_W-1:0] ltr, input logic last);
        t_verdict v;
        case (cmd)
            lmwc_pkg::CMD_CLEAR: empty_pool();
            lmwc_pkg::CMD_ADD: begin
                if (ltr < ALPHABET && pool_total < MAX_LETTERS) begin
                    pool_cnt[ltr]++;
                    pool_total++;
                end
            end
            lmwc_pkg::CMD_WORD: begin
                if (word_len < MAX_LETTERS + 1) word_len++;
                if (ltr < ALPHABET && used_cnt[ltr] < pool_cnt[ltr]) used_cnt[ltr]++;
                else short_flag = 1'b1;
                if (last) begin
                    if (word_len > pool_total || word_len > max_len)
                        v.verdict = lmwc_pkg::VERDICT_LONG;
                    else if (word_len < min_len)
                        v.verdict = lmwc_pkg::VERDICT_SHORT;
                    else if (short_flag)
                        v.verdict = lmwc_pkg::VERDICT_MISSING;
                    else
                        v.verdict = lmwc_pkg::VERDICT_MATCH;
                    v.word_length = 5'(word_len);
                    v.pool_size   = 4'(pool_total);
                    verdicts_due.insert(verdicts_due.size(), v);
                    forget_word();
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_verdict seen;
        t_verdict want;
        if (!i_rst_n) begin
            empty_pool();
            forget_word();
            min_len = lmwc_pkg::MIN_LEN_RST;
            max_len = lmwc_pkg::MAX_LEN_RST;
            verdicts_due.delete();
            fails = 0;
        end else begin
            // results first: a verdict can never leave in the cycle its letter enters
            if (i_res.valid && i_res.ready) begin
                seen.verdict     = i_res.verdict;
                seen.word_length = i_res.word_length;
                seen.pool_size   = i_res.pool_size;
                if (verdicts_due.size() == 0) begin
                    if (fails < REPORT_LIMIT)
                        $display("%0t: unexpected result verdict %0d length %0d pool %0d",
                                 $realtime, seen.verdict, seen.word_length, seen.pool_size);
                    fails++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (seen !== want) begin
                        if (fails < REPORT_LIMIT)
                            $display({"%0t: mismatch, expected verdict %0d length %0d ",
                                      "pool %0d, got verdict %0d length %0d pool %0d"},
                                     $realtime, want.verdict, want.word_length,
                                     want.pool_size, seen.verdict, seen.word_length,
                                     seen.pool_size);
                        fails++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    lmwc_pkg::CFG_MIN_LEN: min_len = i_cfg.data;
                    lmwc_pkg::CFG_MAX_LEN: max_len = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready)
                spell(i_req.command, i_req.letter, i_req.last_letter);
        end
        o_pending    <= verdicts_due.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the letter multiset word checker: drives requests and
// register writes, stalls the result side, and gives the verdict.
// Depends on lmwc_pkg, the channel interfaces, the RTL and lmwc_verdict_checker.
module tb;

    localparam int ITEMS          = 1450;
    localparam int PHASE_ITEMS    = 180;
    localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles; well above the long hold-off
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off for back-pressure
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int POOL_CAP       = 15;
    localparam int LW             = lmwc_pkg::LETTER_W;
    localparam int CW             = lmwc_pkg::CFG_W;

    // command code the block ignores
    localparam logic [lmwc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int  pending;
    int  fail_count;
    int  sent        = 0;      // commands 0..2 accepted so far
    int  quiet_cycles = 0;
    bit  no_gaps     = 1'b0;   // full-rate stretch on both sides
    bit  hold_req    = 1'b0;   // stimulus asks the receiver for a long hold-off
    bit  hold_active = 1'b0;

    // tb's own view of the pool, only to shape words that can be spelled
    logic [LW-1:0] pool_letters[$];
    logic [LW-1:0] spelled[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lmwc_in_if  req_ch ();
    lmwc_out_if res_ch ();
    lmwc_cfg_if cfg_ch ();

    letter_multiset_word_checker_top #(
        .MAX_LETTERS (POOL_CAP),
        .ALPHABET    (256)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    lmwc_verdict_checker #(
        .MAX_LETTERS (POOL_CAP),
        .ALPHABET    (256)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // One request. Leaves valid high after the handshake so the next request
    // can follow back-to-back; any caller that then waits must lower it.
    task automatic send_req(input logic [lmwc_pkg::CMD_W-1:0] cmd,
                            input logic [LW-1:0] ltr, input logic last);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= cmd;
        req_ch.letter      <= ltr;
        req_ch.last_letter <= last;
        do @(posedge clk); while (!req_ch.ready);
        if (cmd != CMD_UNUSED) sent++;
    endtask

    // last_letter means nothing for clear and add, so it is randomized there
    task automatic clear_pool();
        send_req(lmwc_pkg::CMD_CLEAR, LW'($urandom), $urandom_range(0, 9) == 0);
        pool_letters.delete();
    endtask

    task automatic add_letter(input logic [LW-1:0] ltr);
        send_req(lmwc_pkg::CMD_ADD, ltr, $urandom_range(0, 9) == 0);
        if (pool_letters.size() < POOL_CAP) pool_letters.insert(pool_letters.size(), ltr);
    endtask

    // Streams the word in spelled[]; rarely slips a clear or an add between
    // letters, which the block must handle mid-word.
    task automatic send_word();
        foreach (spelled[i]) begin
            if (i < spelled.size() - 1 && $urandom_range(0, 49) == 0) begin
                if ($urandom_range(0, 1) == 0) clear_pool();
                else add_letter(LW'($urandom));
            end
            send_req(lmwc_pkg::CMD_WORD, spelled[i], i == spelled.size() - 1);
        end
    endtask

    // Mostly anagrams of part of the pool; otherwise near-miss letters,
    // long words that saturate the length, or arbitrary codes.
    task automatic build_word(input logic [LW-1:0] base);
        int kind;
        int idx;
        logic [LW-1:0] bag[$];
        spelled.delete();
        bag  = pool_letters;
        kind = $urandom_range(0, 99);
        if (kind < 50 && bag.size() > 0) begin
            repeat ($urandom_range(1, bag.size())) begin
                idx = $urandom_range(0, bag.size() - 1);
                spelled.insert(spelled.size(), bag[idx]);
                bag.delete(idx);
            end
        end else if (kind < 75) begin
            repeat ($urandom_range(1, 8))
                spelled.insert(spelled.size(), LW'(base + $urandom_range(0, 5)));
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 20))
                spelled.insert(spelled.size(),
                               bag.size() > 0 ? bag[$urandom_range(0, bag.size() - 1)]
                                              : base);
        end else begin
            repeat ($urandom_range(1, 6)) spelled.insert(spelled.size(), LW'($urandom));
        end
    endtask

    // One pool setup followed by a handful of words.
    task automatic run_round();
        int k;
        logic [LW-1:0] base;
        no_gaps = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) < 8) clear_pool();
        base = LW'($urandom);
        // sometimes overfill so that adds to a full pool get dropped
        k = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 15);
        repeat (k) begin
            if ($urandom_range(0, 6) == 0) add_letter(LW'($urandom));
            else add_letter(LW'(base + $urandom_range(0, 5)));
        end
        repeat ($urandom_range(1, 5)) begin
            build_word(base);
            send_word();
        end
        if ($urandom_range(0, 9) == 0)
            send_req(CMD_UNUSED, LW'($urandom), $urandom_range(0, 1));
        no_gaps = 1'b0;
    endtask

    // Lowers valid, waits until every verdict is in, then lets the pipeline settle.
    task automatic wait_idle(input int settle);
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Writes both length limits back-to-back; valid drops only after the pair.
    task automatic set_lengths(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= lmwc_pkg::CFG_MIN_LEN;
        cfg_ch.data  <= lo;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= lmwc_pkg::CFG_MAX_LEN;
        cfg_ch.data  <= hi;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Receiver holds off for a long stretch while one-letter words stream in
    // at full rate, so results back up and the block stalls its input.
    // Called right after set_lengths, which follows wait_idle, so valid is already low.
    task automatic pressure_burst();
        hold_req = 1'b1;
        do @(posedge clk); while (!hold_active);
        no_gaps = 1'b1;
        clear_pool();
        repeat (3) add_letter(LW'($urandom));
        repeat (40) begin
            spelled.delete();
            spelled.insert(0, pool_letters[$urandom_range(0, pool_letters.size() - 1)]);
            send_word();
        end
        no_gaps = 1'b0;
    endtask

    // Result side: random ready with short and long stalls, full-rate
    // stretches, and the one long hold-off on request.
    initial begin
        int g;
        res_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req     = 1'b0;
                hold_active  = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active  = 1'b0;
            end else if (no_gaps) begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                g = idle_len();
                if (g > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
        end
    end

    // Watchdog: too long with no handshake on any channel ends the run.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int target;
        logic [CW-1:0] lo_set[6];
        logic [CW-1:0] hi_set[6];
        // length settings per phase: six fixed pairs first, random ones after
        lo_set = '{4'd0, 4'd15, 4'd0, 4'd3, 4'd15, 4'd2};
        hi_set = '{4'd15, 4'd15, 4'd0, 4'd9, 4'd0, 4'd15};

        req_ch.valid       = 1'b0;
        req_ch.command     = lmwc_pkg::CMD_CLEAR;
        req_ch.letter      = '0;
        req_ch.last_letter = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = lmwc_pkg::CFG_MIN_LEN;
        cfg_ch.data        = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset limits (min 2, max 15).
        // word against an empty pool: too long
        send_req(lmwc_pkg::CMD_WORD, "a", 1'b1);
        add_letter("a");
        add_letter("b");
        add_letter("a");
        // single letter under min length: too short
        send_req(lmwc_pkg::CMD_WORD, "a", 1'b1);
        // plain match
        send_req(lmwc_pkg::CMD_WORD, "a", 1'b0);
        send_req(lmwc_pkg::CMD_WORD, "b", 1'b1);
        // third 'a' over-uses the pool: letters missing
        send_req(lmwc_pkg::CMD_WORD, "a", 1'b0);
        send_req(lmwc_pkg::CMD_WORD, "a", 1'b0);
        send_req(lmwc_pkg::CMD_WORD, "a", 1'b1);
        // lowest and highest letter codes, last flag set on an add
        send_req(lmwc_pkg::CMD_ADD, 8'h00, 1'b0);
        send_req(lmwc_pkg::CMD_ADD, 8'hFF, 1'b1);
        send_req(lmwc_pkg::CMD_WORD, 8'hFF, 1'b0);
        send_req(lmwc_pkg::CMD_WORD, 8'h00, 1'b1);
        // unused command with last set: no result
        send_req(CMD_UNUSED, 8'hAA, 1'b1);
        // pool cleared mid-word: word keeps its length, now too long
        send_req(lmwc_pkg::CMD_WORD, 8'h55, 1'b0);
        send_req(lmwc_pkg::CMD_CLEAR, 8'hAA, 1'b1);
        pool_letters.delete();
        send_req(lmwc_pkg::CMD_WORD, "b", 1'b1);

        // Random phases, each under its own length limits.
        for (int p = 0; sent < ITEMS; p++) begin
            wait_idle(SETTLE_CYCLES);
            if (p < 6) set_lengths(lo_set[p], hi_set[p]);
            else       set_lengths(CW'($urandom), CW'($urandom));
            if (p == 2) begin
                pressure_burst();
                wait_idle(SETTLE_CYCLES);
            end
            target = sent + PHASE_ITEMS;
            while (sent < target && sent < ITEMS) run_round();
        end

        wait_idle(DRAIN_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
